/* sv/cal_pkg.sv */
// ----------------------------------------------------------------------------
// cal_pkg
// Shared constants and types for the cursor array list.
// ----------------------------------------------------------------------------
package cal_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam int MODE_W   = 4;
	localparam int ITEM_W   = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 4'd1;
	localparam logic [MODE_W-1:0] MODE_APPEND = 4'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 4'd3;
	localparam logic [MODE_W-1:0] MODE_START  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_END    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_PREV   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_NEXT   = 4'd7;
	localparam logic [MODE_W-1:0] MODE_MOVE   = 4'd8;
	localparam logic [MODE_W-1:0] MODE_READ   = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_ELEM  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd3;

	typedef struct packed {
		logic ins;
		logic app;
		logic rem;
	} cal_shift_t;

endpackage

/* sv/cal_cell.sv */
// ----------------------------------------------------------------------------
// cal_cell
// One list entry; loads the item, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module cal_cell #(
	parameter int IDX        = 0,
	parameter int CW         = 5,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cal_pkg::cal_shift_t   shift,
	input  logic [CW-1:0]         cursor,
	input  logic [CW-1:0]         count,
	input  logic [DATA_WIDTH-1:0] item,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data
);
	import cal_pkg::*;

	localparam logic [CW:0] IDX_C = (CW+1)'(IDX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [CW:0]           cur_e;
	logic [CW:0]           cnt_e;

	assign cur_e = {1'b0, cursor};
	assign cnt_e = {1'b0, count};

	always_ff @(posedge clk) begin
		if (shift.ins) begin
			if (IDX_C == cur_e)
				data_q <= item;
			else if (IDX_C > cur_e && IDX_C <= cnt_e)
				data_q <= left_data;
		end else if (shift.app) begin
			if (IDX_C == cnt_e)
				data_q <= item;
		end else if (shift.rem) begin
			if (IDX_C >= cur_e && IDX_C + 1'b1 < cnt_e)
				data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

/* sv/cal_ctrl.sv */
// ----------------------------------------------------------------------------
// cal_ctrl
// Command decode, length and cursor registers, capacity register, status.
// ----------------------------------------------------------------------------
module cal_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_en,
	input  logic [cal_pkg::MODE_W-1:0] mode,
	input  logic [cal_pkg::POS_W-1:0]  position,
	input  logic                      cfg_wr_en,
	input  logic [cal_pkg::CAP_W-1:0]  cfg_wr_data,
	output cal_pkg::cal_shift_t       shift,
	output logic [CW-1:0]             count,
	output logic [CW-1:0]             cursor,
	output logic [CW-1:0]             count_nxt,
	output logic [CW-1:0]             cursor_nxt,
	output logic [cal_pkg::STATUS_W-1:0] status
);
	import cal_pkg::*;

	localparam int LW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    cursor_q;
	logic [CAP_W-1:0] cap_q;
	logic [LW-1:0]    cnt_e;
	logic [LW-1:0]    cap_e;
	logic [LW-1:0]    pos_e;
	logic             full;
	logic             no_elem;

	assign cnt_e   = LW'(count_q);
	assign cap_e   = LW'(cap_q);
	assign pos_e   = LW'(position);
	assign full    = (cnt_e >= cap_e) || (cnt_e >= LW'(CAPACITY));
	assign no_elem = cursor_q >= count_q;

	always_comb begin
		count_nxt  = count_q;
		cursor_nxt = cursor_q;
		status     = ST_OK;
		shift      = '0;
		case (mode)
			MODE_CLEAR: begin
				count_nxt  = '0;
				cursor_nxt = '0;
			end
			MODE_INSERT, MODE_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
					shift.ins = (mode == MODE_INSERT);
					shift.app = (mode == MODE_APPEND);
				end
			end
			MODE_REMOVE: begin
				if (no_elem) begin
					status = ST_NO_ELEM;
				end else begin
					count_nxt = count_q - 1'b1;
					shift.rem = 1'b1;
				end
			end
			MODE_START: cursor_nxt = '0;
			MODE_END:   cursor_nxt = count_q;
			MODE_PREV: begin
				if (cursor_q != '0)
					cursor_nxt = cursor_q - 1'b1;
			end
			MODE_NEXT: begin
				if (cursor_q < count_q)
					cursor_nxt = cursor_q + 1'b1;
			end
			MODE_MOVE: begin
				if (pos_e > cnt_e)
					status = ST_BAD_POS;
				else
					cursor_nxt = CW'(position);
			end
			MODE_READ: begin
				if (no_elem)
					status = ST_NO_ELEM;
			end
			default: begin
			end
		endcase
		if (!cmd_en)
			shift = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			cap_q    <= CAP_RESET;
		end else begin
			if (cmd_en) begin
				count_q  <= count_nxt;
				cursor_q <= cursor_nxt;
			end
			if (cfg_wr_en)
				cap_q <= cfg_wr_data;
		end
	end

	assign count  = count_q;
	assign cursor = cursor_q;

endmodule

/* sv/cursor_array_list.sv */
// ----------------------------------------------------------------------------
// cursor_array_list
// Ordered list of values with a cursor, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Start is taken at any edge (busy stays low), and the result shows on the
// result ports with done high in the next cycle only. Insert and remove
// move all later entries at once, since each cell loads its neighbor in
// parallel. The receiver cannot stall; results
// must be taken when done is high. No clearing pass runs after reset.
module cursor_array_list #(
	parameter int CAPACITY   = cal_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = cal_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cal_pkg::MODE_W-1:0]   mode,
	input  logic [cal_pkg::ITEM_W-1:0]   item_value,
	input  logic [cal_pkg::POS_W-1:0]    position,
	input  logic                         cfg_wr_en,
	input  logic [cal_pkg::CAP_W-1:0]    cfg_wr_data,
	output logic                         done,
	output logic [cal_pkg::ITEM_W-1:0]   read_value,
	output logic [cal_pkg::STATUS_W-1:0] status,
	output logic [cal_pkg::POS_W-1:0]    list_length,
	output logic [cal_pkg::POS_W-1:0]    cursor_pos
);
	import cal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	cal_shift_t            shift;
	logic                  cmd_en;
	logic [CW-1:0]         count;
	logic [CW-1:0]         cursor;
	logic [CW-1:0]         count_nxt;
	logic [CW-1:0]         cursor_nxt;
	logic [STATUS_W-1:0]   st;
	logic [DATA_WIDTH-1:0] item;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] sel_data;
	logic [DATA_WIDTH-1:0] rv;

	logic                  done_q;
	logic [ITEM_W-1:0]     read_value_q;
	logic [STATUS_W-1:0]   status_q;
	logic [POS_W-1:0]      length_q;
	logic [POS_W-1:0]      cursor_pos_q;

	assign busy   = 1'b0;
	assign cmd_en = start && !busy;
	assign item   = DATA_WIDTH'(item_value);

	cal_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_en      (cmd_en),
		.mode        (mode),
		.position    (position),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.shift       (shift),
		.count       (count),
		.cursor      (cursor),
		.count_nxt   (count_nxt),
		.cursor_nxt  (cursor_nxt),
		.status      (st)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		cal_cell #(
			.IDX        (i),
			.CW         (CW),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.shift      (shift),
			.cursor     (cursor),
			.count      (count),
			.item       (item),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	always_comb begin
		sel_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cursor == CW'(i))
				sel_data = sel_data | cell_data[i];
		end
	end

	assign rv = ((mode == MODE_REMOVE || mode == MODE_READ) && st == ST_OK)
		? sel_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd_en;
	end

	always_ff @(posedge clk) begin
		if (cmd_en) begin
			read_value_q <= ITEM_W'(rv);
			status_q     <= st;
			length_q     <= POS_W'(count_nxt);
			cursor_pos_q <= POS_W'(cursor_nxt);
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign list_length = length_q;
	assign cursor_pos  = cursor_pos_q;

endmodule

/* tb/sv/cursor_array_list_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_array_list_test
// Self-checking bench for the cursor array list. Commands are sent with random
// gaps, every result is predicted by a shadow copy of the list and checked
// field by field. The run steps through several capacity settings, from zero
// up to the all-ones register value, and keeps the list contents across them.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [cal_pkg::ITEM_W-1:0]   read_value;
	logic [cal_pkg::STATUS_W-1:0] status;
	logic [cal_pkg::POS_W-1:0]    list_length;
	logic [cal_pkg::POS_W-1:0]    cursor_pos;
} list_result_t;

class list_tracker;
	logic [cal_pkg::ITEM_W-1:0] cells [cal_pkg::DEF_CAPACITY];
	int unsigned                count;
	int unsigned                cur;
	logic [cal_pkg::CAP_W-1:0]  cap_reg;
	list_result_t               pending_results[$];
	int                         errors;

	function new();
		count   = 0;
		cur     = 0;
		cap_reg = cal_pkg::CAP_RESET;
		errors  = 0;
		foreach (cells[i]) cells[i] = '0;
	endfunction

	function int unsigned entry_limit();
		return (cap_reg < cal_pkg::DEF_CAPACITY) ? cap_reg : cal_pkg::DEF_CAPACITY;
	endfunction

	function list_result_t apply_command(logic [cal_pkg::MODE_W-1:0] md,
			logic [cal_pkg::ITEM_W-1:0] val, logic [cal_pkg::POS_W-1:0] pos);
		list_result_t r;
		r = '0;
		r.status = cal_pkg::ST_OK;
		case (md)
			cal_pkg::MODE_CLEAR: begin
				count = 0;
				cur = 0;
			end
			cal_pkg::MODE_INSERT: begin
				if (count >= entry_limit()) begin
					r.status = cal_pkg::ST_FULL;
				end else begin
					for (int i = count; i > cur; i--) cells[i] = cells[i-1];
					cells[cur] = val;
					count++;
				end
			end
			cal_pkg::MODE_APPEND: begin
				if (count >= entry_limit()) begin
					r.status = cal_pkg::ST_FULL;
				end else begin
					cells[count] = val;
					count++;
				end
			end
			cal_pkg::MODE_REMOVE: begin
				if (cur >= count) begin
					r.status = cal_pkg::ST_NO_ELEM;
				end else begin
					r.read_value = cells[cur];
					for (int i = cur; i + 1 < count; i++) cells[i] = cells[i+1];
					count--;
				end
			end
			cal_pkg::MODE_START: cur = 0;
			cal_pkg::MODE_END:   cur = count;
			cal_pkg::MODE_PREV: begin
				if (cur != 0) cur--;
			end
			cal_pkg::MODE_NEXT: begin
				if (cur < count) cur++;
			end
			cal_pkg::MODE_MOVE: begin
				if (pos > count) r.status = cal_pkg::ST_BAD_POS;
				else cur = pos;
			end
			cal_pkg::MODE_READ: begin
				if (cur >= count) r.status = cal_pkg::ST_NO_ELEM;
				else r.read_value = cells[cur];
			end
			default: ;
		endcase
		r.list_length = count[cal_pkg::POS_W-1:0];
		r.cursor_pos  = cur[cal_pkg::POS_W-1:0];
		return r;
	endfunction

	function void take_command(logic [cal_pkg::MODE_W-1:0] md,
			logic [cal_pkg::ITEM_W-1:0] val, logic [cal_pkg::POS_W-1:0] pos);
		pending_results.push_back(apply_command(md, val, pos));
	endfunction

	function void match_result(list_result_t got);
		list_result_t exp;
		if (pending_results.size() == 0) begin
			$error("result with no command pending");
			errors++;
			return;
		end
		exp = pending_results.pop_front();
		if (got.read_value !== exp.read_value) begin
			$error("read_value: expected %h, got %h", exp.read_value, got.read_value);
			errors++;
		end
		if (got.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, got.status);
			errors++;
		end
		if (got.list_length !== exp.list_length) begin
			$error("list_length: expected %0d, got %0d", exp.list_length, got.list_length);
			errors++;
		end
		if (got.cursor_pos !== exp.cursor_pos) begin
			$error("cursor_pos: expected %0d, got %0d", exp.cursor_pos, got.cursor_pos);
			errors++;
		end
	endfunction
endclass

module cursor_array_list_test;
	import cal_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [MODE_W-1:0]   mode;
	logic [ITEM_W-1:0]   item_value;
	logic [POS_W-1:0]    position;
	logic                cfg_wr_en;
	logic [CAP_W-1:0]    cfg_wr_data;
	logic                done;
	logic [ITEM_W-1:0]   read_value;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    list_length;
	logic [POS_W-1:0]    cursor_pos;

	list_tracker board;
	bit          no_gaps;

	cursor_array_list uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.item_value (item_value),
		.position   (position),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.list_length(list_length),
		.cursor_pos (cursor_pos)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// result check first, then note a new transfer
	always @(posedge clk) begin
		if (arst_n && board != null) begin
			if (done) board.match_result({read_value, status, list_length, cursor_pos});
			if (start && !busy) board.take_command(mode, item_value, position);
		end
	end

	task automatic send_command(logic [MODE_W-1:0] md, logic [ITEM_W-1:0] val,
			logic [POS_W-1:0] pos);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= md;
		item_value <= val;
		position   <= pos;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] cap);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.cap_reg = cap;
	endtask

	task automatic random_command();
		int                  pick;
		logic [MODE_W-1:0]   md;
		logic [POS_W-1:0]    pos;
		pick = $urandom_range(0, 99);
		if      (pick < 3)  md = MODE_CLEAR;
		else if (pick < 25) md = MODE_INSERT;
		else if (pick < 40) md = MODE_APPEND;
		else if (pick < 55) md = MODE_REMOVE;
		else if (pick < 60) md = MODE_START;
		else if (pick < 65) md = MODE_END;
		else if (pick < 72) md = MODE_PREV;
		else if (pick < 79) md = MODE_NEXT;
		else if (pick < 88) md = MODE_MOVE;
		else if (pick < 97) md = MODE_READ;
		else                md = MODE_READ + 4'($urandom_range(1, 6));
		if ($urandom_range(0, 3) == 0) pos = POS_W'($urandom_range(0, 31));
		else pos = POS_W'($urandom_range(0, board.count + 1));
		send_command(md, $urandom, pos);
	endtask

	initial begin
		logic [CAP_W-1:0] caps [];
		caps        = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd3,
			5'd16, 5'd12, 5'd2, 5'd16};
		board       = new();
		no_gaps     = 1'b0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		mode        <= MODE_CLEAR;
		item_value  <= '0;
		position    <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= CAP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases on an empty, then small list
		send_command(MODE_REMOVE, 32'hDEAD_BEEF, '0);
		send_command(MODE_READ,   '0, '0);
		send_command(MODE_PREV,   '0, '0);
		send_command(MODE_NEXT,   '0, '0);
		send_command(MODE_MOVE,   '0, 5'd1);
		send_command(MODE_MOVE,   '0, '0);
		send_command(MODE_APPEND, '1, '0);
		send_command(MODE_APPEND, '0, '1);
		send_command(MODE_INSERT, 32'h1234_5678, '0);
		send_command(MODE_MOVE,   '0, '1);
		send_command(MODE_MOVE,   '0, 5'd3);
		send_command(MODE_NEXT,   '0, '0);
		send_command(MODE_READ,   '0, '0);
		send_command(MODE_PREV,   '0, '0);
		send_command(MODE_READ,   '0, '0);
		send_command(MODE_REMOVE, '0, '0);
		send_command(MODE_START,  '0, '0);
		send_command(MODE_READ,   '0, '0);
		send_command(MODE_REMOVE, '0, '0);
		send_command(MODE_END,    '0, '0);
		send_command(MODE_READ + 4'd1, 32'h5555_AAAA, 5'h15);
		send_command({MODE_W{1'b1}},   32'hAAAA_5555, 5'h0A);
		send_command(MODE_CLEAR,  '0, '0);

		// capacity phases; contents carry over so lower limits see fuller lists
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (138) random_command();
		end
		no_gaps = 1'b0;

		drain_results();
		repeat (5) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (board.pending_results.size() != 0)
				$error("%0d results never arrived", board.pending_results.size());
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

/* cursor_array_list.f */
sv/cal_pkg.sv
sv/cal_cell.sv
sv/cal_ctrl.sv
sv/cursor_array_list.sv
tb/sv/cursor_array_list_test.sv
